// File: src/rc4sd_pkg.sv
// ----------------------------------------------------------------------------
// rc4sd_pkg
// Shared types and constants of the rc4 stream decryptor with md5 rekeying.
// ----------------------------------------------------------------------------
`default_nettype none

package rc4sd_pkg;

    localparam int REKEY_BYTES_DEF = 512;

    localparam logic [31:0] MD5_IV_A = 32'h67452301;
    localparam logic [31:0] MD5_IV_B = 32'hefcdab89;
    localparam logic [31:0] MD5_IV_C = 32'h98badcfe;
    localparam logic [31:0] MD5_IV_D = 32'h10325476;

    localparam logic [7:0] MD5_PAD_BYTE = 8'h80;
    localparam logic [31:0] MD5_BIT_LEN = 32'h00000048;

    localparam logic [31:0] MD5_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] MD5_ROT [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    // message word index for round i
    function automatic logic [3:0] md5_g(input logic [5:0] i);
        logic [3:0] r;
        logic [3:0] g;
        r = i[3:0];
        unique case (i[5:4])
            2'd0: g = r;
            2'd1: g = 4'(r * 4'd5 + 4'd1);
            2'd2: g = 4'(r * 4'd3 + 4'd5);
            2'd3: g = 4'(r * 4'd7);
            default: g = r;
        endcase
        return g;
    endfunction

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MD5,
        ST_MD5_WAIT,
        ST_INIT,
        ST_K0,
        ST_K1,
        ST_K2,
        ST_K3,
        ST_A0,
        ST_A1,
        ST_A2,
        ST_A3,
        ST_A4,
        ST_A5
    } seq_state_t;

    typedef struct packed {
        logic       en;
        logic [7:0] addr;
        logic [7:0] data;
    } sbox_wr_t;

endpackage

`default_nettype wire

// File: src/rc4sd_sbox.sv
// ----------------------------------------------------------------------------
// rc4sd_sbox
// 256 x 8 permutation memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4sd_sbox
    import rc4sd_pkg::*;
(
    input  wire logic       aclk,
    input  wire sbox_wr_t   wr,
    input  wire logic [7:0] raddr,
    output logic [7:0]      rdata
);

    logic [7:0] mem [256];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: src/rc4sd_md5.sv
// ----------------------------------------------------------------------------
// rc4sd_md5
// Iterative md5 compression over the fixed 9-byte key block, each round
// as a sum into t_reg and then a rotate and add into b_reg on one rotator.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4sd_md5
    import rc4sd_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         start,
    input  wire logic [39:0]  key_prefix,
    input  wire logic [31:0]  block_number,
    output logic              done,
    output logic [127:0]      digest
);

    logic [31:0] a_reg, b_reg, c_reg, d_reg, t_reg;
    logic [5:0]  rnd_reg;
    logic        phase_reg, busy_reg, done_reg;
    logic [31:0] f, m;
    logic [3:0]  g;
    logic [4:0]  s;
    logic [63:0] rot;

    always_comb begin
        unique case (rnd_reg[5:4])
            2'd0: f = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1: f = (d_reg & b_reg) | (~d_reg & c_reg);
            2'd2: f = b_reg ^ c_reg ^ d_reg;
            2'd3: f = c_reg ^ (b_reg | ~d_reg);
            default: f = '0;
        endcase
        g = md5_g(rnd_reg);
        unique case (g)
            4'd0:  m = key_prefix[31:0];
            4'd1:  m = {block_number[23:0], key_prefix[39:32]};
            4'd2:  m = {16'h0000, MD5_PAD_BYTE, block_number[31:24]};
            4'd14: m = MD5_BIT_LEN;
            default: m = '0;
        endcase
        s   = MD5_ROT[{rnd_reg[5:4], rnd_reg[1:0]}];
        rot = {t_reg, t_reg} << s;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= 1'b0;
            rnd_reg   <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg  <= 1'b1;
                phase_reg <= 1'b0;
                rnd_reg   <= '0;
                a_reg     <= MD5_IV_A;
                b_reg     <= MD5_IV_B;
                c_reg     <= MD5_IV_C;
                d_reg     <= MD5_IV_D;
            end else if (busy_reg) begin
                phase_reg <= ~phase_reg;
                if (!phase_reg) begin
                    t_reg <= a_reg + f + MD5_K[rnd_reg] + m;
                end else begin
                    a_reg   <= d_reg;
                    d_reg   <= c_reg;
                    c_reg   <= b_reg;
                    b_reg   <= b_reg + rot[63:32];
                    rnd_reg <= 6'(rnd_reg + 6'd1);
                    if (rnd_reg == 6'd63) begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                end
            end
        end
    end

    assign done   = done_reg;
    assign digest = {d_reg + MD5_IV_D, c_reg + MD5_IV_C, b_reg + MD5_IV_B, a_reg + MD5_IV_A};

endmodule

`default_nettype wire

// File: src/rc4_stream_decrypt_block_rekey_core.sv
// ----------------------------------------------------------------------------
// rc4_stream_decrypt_block_rekey_core
// RC4 stream decryptor, rekeyed by md5 over the key prefix and block number.
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  s_       | in        | tdata: cipher_byte[7:0], tuser: restart
//  m_       | out       | tdata: plain_byte[7:0]
//  cfg_     | in        | data: key_prefix[39:0]
//
//  a byte without rekey takes the accept cycle and six sequencer
//  steps (two reads, a swap through the single write port, the keystream read)
//  the result is registered onto m_ as the sequencer leaves its last step
//  a rekey adds the md5 start and wait, the table fill and the key schedule
//  (states K0 to K3 for each table entry) before that byte
//  reset is synchronous; the permutation memory is never cleared
//  a result waiting on m_ only holds the sequencer in its last step
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_stream_decrypt_block_rekey_core
    import rc4sd_pkg::*;
#(
    parameter int REKEY_BYTES = REKEY_BYTES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // cipher_byte[7:0]
    input  wire logic        s_tuser,   // restart
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // plain_byte[7:0]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [39:0] cfg_data
);

    localparam int CW = $clog2(REKEY_BYTES);

    seq_state_t state_reg, state_next;

    logic [39:0]  kp_reg;
    logic [31:0]  bn_reg, bn_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic         keyed_reg, keyed_next;
    logic [7:0]   ia_reg, ia_next, ib_reg, ib_next, i_reg, i_next, j_reg, j_next;
    logic [7:0]   si_reg, si_next, sj_reg, sj_next, cb_reg, cb_next;
    logic [127:0] dig_reg;
    logic         mv_reg, mv_next;
    logic [7:0]   md_reg, md_next;

    logic         md5_start, md5_done;
    logic [127:0] md5_digest;
    sbox_wr_t     wr;
    logic [7:0]   raddr, rdata;
    logic         in_acc;

    rc4sd_md5 u_md5 (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (md5_start),
        .key_prefix   (kp_reg),
        .block_number (bn_reg),
        .done         (md5_done),
        .digest       (md5_digest)
    );

    rc4sd_sbox u_sbox (
        .aclk  (aclk),
        .wr    (wr),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign cfg_ready = (state_reg == ST_IDLE);
    assign m_tvalid  = mv_reg;
    assign m_tdata   = md_reg;
    assign md5_start = (state_reg == ST_MD5);

    always_comb begin
        state_next = state_reg;
        bn_next    = bn_reg;
        cnt_next   = cnt_reg;
        keyed_next = keyed_reg;
        ia_next    = ia_reg;
        ib_next    = ib_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        si_next    = si_reg;
        sj_next    = sj_reg;
        cb_next    = cb_reg;
        mv_next    = mv_reg && !m_tready;
        md_next    = md_reg;
        wr         = '0;
        raddr      = i_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    cb_next = s_tdata;
                    if (s_tuser) begin
                        bn_next  = '0;
                        cnt_next = '0;
                    end
                    state_next = (s_tuser || !keyed_reg) ? ST_MD5 : ST_A0;
                end
            end
            ST_MD5: state_next = ST_MD5_WAIT;
            ST_MD5_WAIT: begin
                if (md5_done) begin
                    i_next     = '0;
                    state_next = ST_INIT;
                end
            end
            ST_INIT: begin
                wr.en   = 1'b1;
                wr.addr = i_reg;
                wr.data = i_reg;
                i_next  = 8'(i_reg + 8'd1);
                if (i_reg == 8'hFF) begin
                    j_next     = '0;
                    state_next = ST_K0;
                end
            end
            ST_K0: state_next = ST_K1;
            ST_K1: begin
                si_next    = rdata;
                j_next     = 8'(j_reg + rdata + dig_reg[{i_reg[3:0], 3'b000} +: 8]);
                raddr      = j_next;
                state_next = ST_K2;
            end
            ST_K2: begin
                wr.en      = 1'b1;
                wr.addr    = i_reg;
                wr.data    = rdata;
                state_next = ST_K3;
            end
            ST_K3: begin
                wr.en   = 1'b1;
                wr.addr = j_reg;
                wr.data = si_reg;
                i_next  = 8'(i_reg + 8'd1);
                if (i_reg == 8'hFF) begin
                    ia_next    = '0;
                    ib_next    = '0;
                    keyed_next = 1'b1;
                    state_next = ST_A0;
                end else begin
                    state_next = ST_K0;
                end
            end
            ST_A0: begin
                ia_next    = 8'(ia_reg + 8'd1);
                raddr      = ia_next;
                state_next = ST_A1;
            end
            ST_A1: begin
                si_next    = rdata;
                ib_next    = 8'(ib_reg + rdata);
                raddr      = ib_next;
                state_next = ST_A2;
            end
            ST_A2: begin
                sj_next    = rdata;
                wr.en      = 1'b1;
                wr.addr    = ia_reg;
                wr.data    = rdata;
                state_next = ST_A3;
            end
            ST_A3: begin
                wr.en      = 1'b1;
                wr.addr    = ib_reg;
                wr.data    = si_reg;
                state_next = ST_A4;
            end
            ST_A4: begin
                // read after the swap has landed
                raddr      = 8'(si_reg + sj_reg);
                state_next = ST_A5;
            end
            ST_A5: begin
                // keep the keystream byte on the read port while m_ is stalled
                raddr = 8'(si_reg + sj_reg);
                if (!mv_reg || m_tready) begin
                    md_next = cb_reg ^ rdata;
                    mv_next = 1'b1;
                    if (cnt_reg == CW'(REKEY_BYTES - 1)) begin
                        cnt_next   = '0;
                        bn_next    = bn_reg + 32'd1;
                        keyed_next = 1'b0;
                    end else begin
                        cnt_next = CW'(cnt_reg + 1'b1);
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            kp_reg    <= '0;
            bn_reg    <= '0;
            cnt_reg   <= '0;
            keyed_reg <= 1'b0;
            ia_reg    <= '0;
            ib_reg    <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                kp_reg <= cfg_data;
            end
            bn_reg    <= bn_next;
            cnt_reg   <= cnt_next;
            keyed_reg <= keyed_next;
            ia_reg    <= ia_next;
            ib_reg    <= ib_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        si_reg <= si_next;
        sj_reg <= sj_next;
        cb_reg <= cb_next;
        md_reg <= md_next;
        if (md5_done) begin
            dig_reg <= md5_digest;
        end
    end

endmodule

`default_nettype wire

// File: src/rc4sd_checker.sv
// ----------------------------------------------------------------------------
// rc4sd_checker
// Port-level checks of the decryptor's handshakes, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4sd_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata
);

    // a waiting result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one byte at a time: s_tready stays low while the sequencer works on a byte after a transaction
    a_busy_window: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready [*6])
        else $error("input taken while a byte is in progress");

    // a result never appears the cycle after its input
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result too early");

endmodule

bind rc4_stream_decrypt_block_rekey_core rc4sd_checker u_rc4sd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// File: tb/sv/rc4_stream_decrypt_block_rekey_core_tb.sv
// ----------------------------------------------------------------------------
// rc4_stream_decrypt_block_rekey_core_tb
// Self-checking bench: streams cipher bytes through the decryptor, predicts
// each plain byte with an md5-rekeyed rc4 model and compares in order.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_stream_decrypt_block_rekey_core_tb
    import rc4sd_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BLOCK_LEN = REKEY_BYTES_DEF;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int RAND_ITEMS = 1250;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [39:0] cfg_data = '0;

    always #2 aclk = ~aclk;

    rc4_stream_decrypt_block_rekey_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // predictor state
    logic [39:0] key_prefix_q;
    logic [7:0]  sbox [256];
    logic [7:0]  idx_i, idx_j;
    int unsigned blk_bytes;
    logic [31:0] blk_num;
    bit          have_key;

    logic [7:0]  plain_q [$];
    int          err_cnt = 0;
    int          byte_cnt = 0;
    int          rekey_cnt = 0;
    int          cycle_cnt = 0;
    bit          idle_on = 1'b1;

    function automatic logic [31:0] rol(logic [31:0] x, int s);
        return (x << s) | (x >> (32 - s));
    endfunction

    function automatic void rekey();
        logic [7:0]  msg [64];
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, f, t;
        logic [7:0]  dig [16];
        logic [7:0]  j, tmp;
        int g;
        foreach (msg[k]) msg[k] = 8'h00;
        for (int k = 0; k < 5; k++) msg[k] = key_prefix_q[8*k +: 8];
        for (int k = 0; k < 4; k++) msg[5+k] = blk_num[8*k +: 8];
        msg[9] = 8'h80;
        msg[56] = 8'h48;
        for (int k = 0; k < 16; k++) w[k] = {msg[4*k+3], msg[4*k+2], msg[4*k+1], msg[4*k]};
        a = 32'h67452301; b = 32'hefcdab89; c = 32'h98badcfe; d = 32'h10325476;
        for (int r = 0; r < 64; r++) begin
            if (r < 16) begin
                f = (b & c) | (~b & d); g = r;
            end else if (r < 32) begin
                f = (d & b) | (~d & c); g = (5*r + 1) & 15;
            end else if (r < 48) begin
                f = b ^ c ^ d; g = (3*r + 5) & 15;
            end else begin
                f = c ^ (b | ~d); g = (7*r) & 15;
            end
            t = d; d = c; c = b;
            b = b + rol(a + f + MD5_K[r] + w[g], MD5_ROT[((r >> 4) << 2) | (r & 3)]);
            a = t;
        end
        a += 32'h67452301; b += 32'hefcdab89; c += 32'h98badcfe; d += 32'h10325476;
        for (int k = 0; k < 4; k++) begin
            dig[k] = a[8*k +: 8]; dig[4+k] = b[8*k +: 8];
            dig[8+k] = c[8*k +: 8]; dig[12+k] = d[8*k +: 8];
        end
        for (int k = 0; k < 256; k++) sbox[k] = 8'(k);
        j = 0;
        for (int k = 0; k < 256; k++) begin
            j = j + sbox[k] + dig[k & 15];
            tmp = sbox[k]; sbox[k] = sbox[j]; sbox[j] = tmp;
        end
        idx_i = 0; idx_j = 0; have_key = 1'b1;
        rekey_cnt++;
    endfunction

    function automatic logic [7:0] decrypt_byte(logic [7:0] cb, bit restart);
        logic [7:0] tmp;
        logic [7:0] ks;
        if (restart) begin
            blk_num = 0; blk_bytes = 0; have_key = 1'b0;
        end
        if (!have_key) rekey();
        idx_i = idx_i + 8'd1;
        idx_j = idx_j + sbox[idx_i];
        tmp = sbox[idx_i]; sbox[idx_i] = sbox[idx_j]; sbox[idx_j] = tmp;
        ks = sbox[8'(sbox[idx_i] + sbox[idx_j])];
        blk_bytes++;
        if (blk_bytes >= BLOCK_LEN) begin
            blk_bytes = 0; blk_num = blk_num + 1; have_key = 1'b0;
        end
        return cb ^ ks;
    endfunction

    task automatic idle_gap();
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    // valid stays up after a transaction until the next byte, a gap or a drain
    task automatic send_byte(logic [7:0] cb, bit restart);
        idle_gap();
        s_tvalid <= 1'b1; s_tdata <= cb; s_tuser <= restart;
        do @(posedge aclk); while (!s_tready);
        plain_q.push_back(decrypt_byte(cb, restart));
        byte_cnt++;
    endtask

    task automatic write_key(logic [39:0] value);
        cfg_valid <= 1'b1; cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        key_prefix_q = value;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        wait (plain_q.size() == 0);
        repeat (20) @(posedge aclk);
    endtask

    // receiver with random stalls
    initial begin
        forever begin
            @(posedge aclk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (aresetn && m_tvalid && m_tready) begin
            if (plain_q.size() == 0) begin
                $error("unexpected plain_byte %0h", m_tdata);
                err_cnt++;
            end else begin
                logic [7:0] exp_b;
                exp_b = plain_q.pop_front();
                if (m_tdata !== exp_b) begin
                    $error("plain_byte expected %0h actual %0h", exp_b, m_tdata);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // first byte without restart keys block zero with the reset prefix
    task automatic test_first_byte_no_restart();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b0);
        drain();
    endtask

    task automatic test_key_extremes();
        write_key(40'hFF_FFFF_FFFF);
        send_byte(8'h5A, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        drain();
        write_key(40'h00_0000_0000);
        send_byte(8'h3C, 1'b1);
        send_byte(8'hC3, 1'b0);
        drain();
    endtask

    // prefix written mid-stream only lands at the next block end
    task automatic test_block_end_and_late_key();
        write_key(40'h12_3456_789A);
        send_byte(8'h01, 1'b1);
        drain();
        write_key(40'hA5_5A00_FF01);
        for (int k = 1; k < BLOCK_LEN + 4; k++) send_byte(8'($urandom), 1'b0);
        drain();
    endtask

    task automatic test_random_streams();
        int n;
        n = 0;
        while (n < RAND_ITEMS) begin
            int len;
            if ($urandom_range(0, 2) == 0) begin
                drain();
                write_key(40'({$urandom, $urandom}));
            end
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(500, 700)
                                              : $urandom_range(1, 60);
            if (len > RAND_ITEMS - n) len = RAND_ITEMS - n;
            for (int k = 0; k < len; k++) begin
                send_byte(8'($urandom), k == 0 ? 1'b1 : ($urandom_range(0, 99) == 0));
                n++;
                if (n > RAND_ITEMS - 250) idle_on = 1'b0;
            end
        end
        drain();
    endtask

    initial begin
        key_prefix_q = '0;
        foreach (sbox[k]) sbox[k] = '0;
        idx_i = 0; idx_j = 0; blk_bytes = 0; blk_num = 0; have_key = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_first_byte_no_restart();
        test_key_extremes();
        test_block_end_and_late_key();
        test_random_streams();
        $display("decrypted %0d bytes across %0d rekeys, with restarts and key changes",
                 byte_cnt, rekey_cnt);
        if (err_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire
